// ===== rtl/core/inest_pkg.sv =====
package inest_pkg;

   // Word layout on the stream ports
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;

   // Field widths
   localparam int VEC_W   = 8;
   localparam int ADDR_W  = 16;
   localparam int DEPTH_W = 8;
   localparam int COUNT_W = 32;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX    = 8'd255;
   localparam logic [ADDR_W-1:0]  WINDOW_RESET = 16'd128;

   typedef enum logic [1:0] {
      FUNC_ENTER  = 2'd0,
      FUNC_RETURN = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_POLL   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_CHECK,
      ST_TOP,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic pop;
      logic rd_top;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      func_type func;
      logic     depth_zero;
      logic     chain_ok;
      logic     in_window;
   } dp_stat_type;

endpackage

// ===== rtl/core/inest_dp.sv =====
module inest_dp
   import inest_pkg::*;
#(
   parameter int FRAME_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  csr_wen,
   input  logic [ADDR_W-1:0]     csr_wdata,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(FRAME_SLOTS);
   localparam logic [DEPTH_W-1:0] SLOTS = DEPTH_W'(FRAME_SLOTS);

   // Frame stores
   logic [ADDR_W-1:0] ra_mem [FRAME_SLOTS];
   logic [ADDR_W-1:0] sp_mem [FRAME_SLOTS];

   // Latched request word
   func_type            func_ff;
   logic [VEC_W-1:0]    vec_ff;
   logic [ADDR_W-1:0]   ra_ff;
   logic [ADDR_W-1:0]   sp_ff;

   // Architectural state
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [VEC_W-1:0]    recent_ff, recent_in;
   logic                mark_ff, mark_in;
   logic [ADDR_W-1:0]   window_ff;

   // Working registers
   logic                flag_out_ff;
   logic [ADDR_W-1:0]   ra_rd_ff;
   logic [ADDR_W-1:0]   sp_rd_ff;
   logic                top_vld_ff;

   // Result word
   logic                rsp_int_ff;
   logic [DEPTH_W-1:0]  rsp_depth_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [VEC_W-1:0]    rsp_vec_ff;
   logic [ADDR_W-1:0]   rsp_ra_ff;
   logic                rsp_flag_ff;

   logic                top_rec;
   logic                chain_ok;
   logic                do_write;
   logic [DEPTH_W-1:0]  depth_m1;
   logic [DEPTH_W-1:0]  depth_m2;
   logic [ADDR_W-1:0]   sp_gap;

   // Frame bookkeeping from the current depth
   assign depth_m1 = depth_ff - 8'd1;
   assign depth_m2 = depth_ff - 8'd2;
   assign top_rec  = (depth_ff != '0) && (depth_ff <= SLOTS);
   assign chain_ok = (depth_ff >= 8'd2) && (depth_ff <= SLOTS);
   assign do_write = cmd.exec && (func_ff == FUNC_ENTER) && (depth_ff < SLOTS);
   assign sp_gap   = sp_ff - sp_rd_ff;

   assign stat.func       = func_ff;
   assign stat.depth_zero = (depth_ff == '0);
   assign stat.chain_ok   = chain_ok;
   assign stat.in_window  = (sp_gap <= window_ff);

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= func_type'(req_tuser);
         vec_ff  <= req_tdata[7:0];
         ra_ff   <= req_tdata[23:8];
         sp_ff   <= req_tdata[39:24];
      end
   end

   // Next architectural state
   always_comb begin
      depth_in  = depth_ff;
      count_in  = count_ff;
      recent_in = recent_ff;
      mark_in   = mark_ff;
      if (cmd.exec) begin
         case (func_ff)
            FUNC_ENTER: begin
               count_in  = count_ff + 32'd1;
               recent_in = vec_ff;
               mark_in   = 1'b1;
               if (depth_ff != DEPTH_MAX) begin
                  depth_in = depth_ff + 8'd1;
               end
            end
            FUNC_CLEAR: begin
               depth_in  = '0;
               count_in  = '0;
               recent_in = '0;
               mark_in   = 1'b0;
            end
            FUNC_POLL: begin
               mark_in = 1'b0;
            end
            default: begin
               mark_in = mark_ff;
            end
         endcase
      end else if (cmd.pop && (depth_ff != '0)) begin
         depth_in = depth_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         count_ff  <= '0;
         recent_ff <= '0;
         mark_ff   <= 1'b0;
         window_ff <= WINDOW_RESET;
      end else begin
         depth_ff  <= depth_in;
         count_ff  <= count_in;
         recent_ff <= recent_in;
         mark_ff   <= mark_in;
         if (csr_wen) begin
            window_ff <= csr_wdata;
         end
      end
   end

   // Flag reported with the result: value before a poll clears it
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         flag_out_ff <= mark_in | (func_ff == FUNC_POLL ? mark_ff : 1'b0);
      end
   end

   // Push a frame on enter
   always_ff @(posedge clock) begin
      if (do_write) begin
         ra_mem[depth_ff[AW-1:0]] <= ra_ff;
         sp_mem[depth_ff[AW-1:0]] <= sp_ff;
      end
   end

   // Fetch the next frame's stack pointer while popping
   always_ff @(posedge clock) begin
      if (cmd.pop && chain_ok) begin
         sp_rd_ff <= sp_mem[depth_m2[AW-1:0]];
      end
   end

   // Fetch the innermost return address
   always_ff @(posedge clock) begin
      if (cmd.rd_top) begin
         top_vld_ff <= top_rec;
         if (top_rec) begin
            ra_rd_ff <= ra_mem[depth_m1[AW-1:0]];
         end
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_int_ff   <= (depth_ff != '0);
         rsp_depth_ff <= depth_ff;
         rsp_count_ff <= count_ff;
         rsp_vec_ff   <= recent_ff;
         rsp_ra_ff    <= top_vld_ff ? ra_rd_ff : '0;
         rsp_flag_ff  <= flag_out_ff;
      end
   end

   assign rsp_tdata = {6'd0, rsp_flag_ff, rsp_ra_ff, rsp_vec_ff,
                       rsp_count_ff, rsp_depth_ff, rsp_int_ff};

endmodule

// ===== rtl/core/inest_ctrl.sv =====
module inest_ctrl
   import inest_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (stat.func == FUNC_RETURN) ? ST_POP : ST_TOP;
         end
         ST_POP: begin
            if (!stat.depth_zero && stat.chain_ok) state_in = ST_CHECK;
            else state_in = ST_TOP;
         end
         ST_CHECK: begin
            state_in = stat.in_window ? ST_POP : ST_TOP;
         end
         ST_TOP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_POP: begin
            cmd.pop = !stat.depth_zero;
         end
         ST_TOP: begin
            cmd.rd_top = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Hold the result until taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/interrupt_nesting_tracker.sv =====
// Flow: enter, clear and poll execute, read the top frame and raise their result word;
//   a return also unwinds further frames (one pop and one window check per frame),
//   bounded by the FRAME_SLOTS frame slots.
// Handshake: one word at a time; the next word is taken once the result is in the output
//   register, even while that result waits.
// Reset: synchronous, active high; clears depth, counter, last vector, flag; window to 128.
module interrupt_nesting_tracker
   import inest_pkg::*;
#(
   parameter int FRAME_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vector[7:0], return_address[23:8], stack_pointer[39:24]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // in_interrupt[0], nest_depth[8:1], taken_total[40:9], last_vector_seen[48:41],
   // top_return_address[64:49], entered_flag[65], zero fill[71:66]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wen,
   input  logic [ADDR_W-1:0]     csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   inest_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   inest_dp #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/core/inest_checker.sv =====
module inest_checker
   import inest_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // In-interrupt marks a nonzero depth
   a_int_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[8:1] != 8'd0))
      else $error("in_interrupt disagrees with depth");

   // No frame means no return address
   a_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:1] == 8'd0) |-> rsp_tdata[64:49] == 16'd0)
      else $error("return address shown at depth zero");

   // Reset drops any pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind interrupt_nesting_tracker inest_checker u_inest_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
